// File: rtl/rsl_pkg.sv
// Shared types and constants for the radial spotlight luminance block.
package rsl_pkg;

   // Field widths
   localparam int COORD_W   = 12;
   localparam int LUM_W     = 16;
   localparam int CTR_W     = 14;
   localparam int CSR_IDX_W = 1;

   // Absolute coordinate difference: up to 4095 + 8192, fits the center width
   localparam int DIFF_W = CTR_W;

   // Distance only matters below the near limit, so the root is narrow
   localparam int NEAR_LIM = 160;
   localparam int ROOT_W   = 8;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 2;
   localparam int SQ_W     = 2 * ROOT_W;
   localparam int SUM_W    = SQ_W + 1;

   localparam logic [DIFF_W-1:0] NEAR_DIFF = DIFF_W'(NEAR_LIM);
   localparam logic [SUM_W-1:0]  NEAR_SQ   = SUM_W'(NEAR_LIM * NEAR_LIM);
   localparam logic [ROOT_W-1:0] NEAR_ROOT = ROOT_W'(NEAR_LIM);

   // Scale = factor / 200; far pixels use factor 40 (= 1/5)
   localparam int FACT_W = 8;
   localparam logic [FACT_W-1:0] FULL_FACT = FACT_W'(200);
   localparam logic [FACT_W-1:0] FAR_FACT  = FACT_W'(40);

   // /200 = (>>3) then /25 by reciprocal; exact for quotients below 2^21
   localparam int PROD_W      = LUM_W + FACT_W;
   localparam int PRE_SHIFT   = 3;
   localparam int QUO_W       = PROD_W - PRE_SHIFT;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_W     = 22;
   localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'((64'd1 << RECIP_SHIFT) / 25 + 1);
   localparam int MUL_W       = QUO_W + RECIP_W;

   // Pipeline depths
   localparam int DIST_STAGES  = 3;
   localparam int SQRT_STAGES  = ROOT_W / 2;
   localparam int SCALE_STAGES = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 1'b0,
      CSR_CENTER_Y = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [LUM_W-1:0]   lum_in;
   } pix_type;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic             far;
      logic [LUM_W-1:0] lum;
   } rad_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              far;
      logic [LUM_W-1:0]  lum;
   } root_type;

endpackage

// File: rtl/rsl_if.sv
// Valid/ready channel interfaces for request, response and register writes.
interface rsl_req_if;
   logic                          valid;
   logic                          ready;
   logic [rsl_pkg::COORD_W-1:0]   pixel_x;
   logic [rsl_pkg::COORD_W-1:0]   pixel_y;
   logic [rsl_pkg::LUM_W-1:0]     lum_in;

   modport source (output valid, pixel_x, pixel_y, lum_in, input ready);
   modport sink   (input valid, pixel_x, pixel_y, lum_in, output ready);
endinterface

interface rsl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rsl_pkg::LUM_W-1:0] lum_out;

   modport source (output valid, lum_out, input ready);
   modport sink   (input valid, lum_out, output ready);
endinterface

interface rsl_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rsl_pkg::CSR_IDX_W-1:0] index;
   logic [rsl_pkg::CTR_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rsl_dist.sv
// Distance front end: abs differences, squares, near/far decision.
module rsl_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  rsl_pkg::pix_type            in_data,
   input  logic [rsl_pkg::CTR_W-1:0]   center_x,
   input  logic [rsl_pkg::CTR_W-1:0]   center_y,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rsl_pkg::rad_type            out_data
);
   import rsl_pkg::*;

   logic [DIST_STAGES-1:0] vld_ff, vld_in, vld_prev;
   logic [DIST_STAGES:0]   rdy;

   logic [DIFF_W-1:0] ax_ff, ay_ff, ax_in, ay_in;
   logic [LUM_W-1:0]  lum1_ff, lum2_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic              far2_ff, far2_in;
   logic [SUM_W-1:0]  sum;
   rad_type           rad_ff, rad_in;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                  input logic [CTR_W-1:0]   c);
      logic [CTR_W:0] d;
      d = {{(CTR_W + 1 - COORD_W){1'b0}}, p} - {c[CTR_W-1], c};
      return d[CTR_W] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // stage advances when empty or when the next one moves
   always_comb begin
      rdy[DIST_STAGES] = out_ready;
      for (int i = DIST_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_prev = {vld_ff[DIST_STAGES-2:0], in_valid};
      for (int i = 0; i < DIST_STAGES; i++) begin
         vld_in[i] = rdy[i] ? vld_prev[i] : vld_ff[i];
      end
   end

   always_comb begin
      ax_in   = abs_diff(in_data.pixel_x, center_x);
      ay_in   = abs_diff(in_data.pixel_y, center_y);
      far2_in = (ax_ff >= NEAR_DIFF) || (ay_ff >= NEAR_DIFF);
      sqx_in  = SQ_W'(ax_ff[ROOT_W-1:0]) * SQ_W'(ax_ff[ROOT_W-1:0]);
      sqy_in  = SQ_W'(ay_ff[ROOT_W-1:0]) * SQ_W'(ay_ff[ROOT_W-1:0]);
      sum     = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      rad_in.rad = sum[RAD_W-1:0];
      rad_in.far = far2_ff || (sum >= NEAR_SQ);
      rad_in.lum = lum2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         lum1_ff <= in_data.lum_in;
      end
      if (rdy[1]) begin
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         far2_ff <= far2_in;
         lum2_ff <= lum1_ff;
      end
      if (rdy[2]) begin
         rad_ff <= rad_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DIST_STAGES-1];
   assign out_data  = rad_ff;

endmodule

// File: rtl/rsl_isqrt.sv
// Pipelined digit-by-digit integer square root, two root bits per stage.
module rsl_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rsl_pkg::rad_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rsl_pkg::root_type out_data
);
   import rsl_pkg::*;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic              far;
      logic [LUM_W-1:0]  lum;
   } sqrt_state_type;

   logic [SQRT_STAGES-1:0] vld_ff, vld_in, vld_prev;
   logic [SQRT_STAGES:0]   rdy;
   sqrt_state_type         st_ff [SQRT_STAGES];
   sqrt_state_type         st_in [SQRT_STAGES];
   sqrt_state_type         st_init;

   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s,
                                                input logic [1:0]     pair);
      sqrt_state_type r;
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] trial;
      r     = s;
      sh    = {s.rem[REM_W-3:0], pair};
      trial = {s.root, 2'b01};
      if (sh >= trial) begin
         r.rem  = sh - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = sh;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      rdy[SQRT_STAGES] = out_ready;
      for (int i = SQRT_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_prev = {vld_ff[SQRT_STAGES-2:0], in_valid};
      for (int i = 0; i < SQRT_STAGES; i++) begin
         vld_in[i] = rdy[i] ? vld_prev[i] : vld_ff[i];
      end
   end

   always_comb begin
      st_init.rad  = in_data.rad;
      st_init.rem  = '0;
      st_init.root = '0;
      st_init.far  = in_data.far;
      st_init.lum  = in_data.lum;
   end

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      // stage s resolves root bits ROOT_W-1-2s and ROOT_W-2-2s
      localparam int HI = RAD_W - 2 - 4 * s;
      localparam int LO = HI - 2;
      if (s == 0) begin : g_first
         assign st_in[s] = sqrt_step(sqrt_step(st_init, st_init.rad[HI +: 2]),
                                     st_init.rad[LO +: 2]);
      end else begin : g_next
         assign st_in[s] = sqrt_step(sqrt_step(st_ff[s-1], st_ff[s-1].rad[HI +: 2]),
                                     st_ff[s-1].rad[LO +: 2]);
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = vld_ff[SQRT_STAGES-1];
   assign out_data.root = st_ff[SQRT_STAGES-1].root;
   assign out_data.far  = st_ff[SQRT_STAGES-1].far;
   assign out_data.lum  = st_ff[SQRT_STAGES-1].lum;

endmodule

// File: rtl/rsl_scale.sv
// Falloff scaling: lum * factor / 200 via reciprocal multiply, output register.
module rsl_scale (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rsl_pkg::root_type         in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [rsl_pkg::LUM_W-1:0] lum_out
);
   import rsl_pkg::*;

   logic [SCALE_STAGES-1:0] vld_ff, vld_in, vld_prev;
   logic [SCALE_STAGES:0]   rdy;

   logic [FACT_W-1:0] fac;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MUL_W-1:0]  mul_ff, mul_in;
   logic [LUM_W-1:0]  lum_out_ff, lum_out_in;

   always_comb begin
      rdy[SCALE_STAGES] = out_ready;
      for (int i = SCALE_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_prev = {vld_ff[SCALE_STAGES-2:0], in_valid};
      for (int i = 0; i < SCALE_STAGES; i++) begin
         vld_in[i] = rdy[i] ? vld_prev[i] : vld_ff[i];
      end
   end

   always_comb begin
      // far: 40/200 = 1/5, same as the fixed dimming
      fac        = in_data.far ? FAR_FACT : (FULL_FACT - in_data.root);
      prod_in    = PROD_W'(in_data.lum) * PROD_W'(fac);
      mul_in     = MUL_W'(prod_ff[PROD_W-1:PRE_SHIFT]) * MUL_W'(RECIP_25);
      lum_out_in = mul_ff[RECIP_SHIFT +: LUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prod_ff <= prod_in;
      end
      if (rdy[1]) begin
         mul_ff <= mul_in;
      end
      if (rdy[2]) begin
         lum_out_ff <= lum_out_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[SCALE_STAGES-1];
   assign lum_out   = lum_out_ff;

endmodule

// File: rtl/radial_spotlight_luminance_top.sv
// Top level of the radial spotlight luminance block.
//
// Usage: one request per pixel on req_if (pixel_x, pixel_y, lum_in), one
// response per request on rsp_if (lum_out), in request order.
// lum_out = floor(lum_in * (200 - d) / 200) when d < 160, else
// floor(lum_in / 5), where d = floor(sqrt(dx^2 + dy^2)) from the center.
// Center registers are written through csr_if (index 0: center_x, index 1:
// center_y, 14-bit two's complement); csr_if is always ready. Write them
// only while no request is in flight.
// Throughput: one request per cycle while rsp_if is ready. Path from
// request acceptance to response valid: 3 distance stages, 4 square-root
// stages at two root bits each, 3 scaling stages ending in the output reg.
// Stall: each stage holds its item while the next one is full and stalled,
// so a stalled rsp_if backs up stage by stage; empty stages keep taking
// new requests until the pipeline is full, and req_if.ready then drops.
// Reset: clears all valid bits and both center registers to 0.
module radial_spotlight_luminance_top (
   input  logic clock,
   input  logic reset,
   rsl_req_if.sink   req_if,
   rsl_rsp_if.source rsp_if,
   rsl_csr_if.sink   csr_if
);
   import rsl_pkg::*;

   // Center registers
   logic [CTR_W-1:0] center_x_ff, center_x_in;
   logic [CTR_W-1:0] center_y_ff, center_y_in;

   // Inter-module channels
   pix_type  pix;
   logic     rad_vld, rad_rdy;
   rad_type  rad_data;
   logic     sq_vld, sq_rdy;
   root_type sq_data;

   assign csr_if.ready = 1'b1;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_if.valid) begin
         unique case (csr_idx_type'(csr_if.index))
            CSR_CENTER_X: center_x_in = csr_if.data;
            CSR_CENTER_Y: center_y_in = csr_if.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   assign pix.pixel_x = req_if.pixel_x;
   assign pix.pixel_y = req_if.pixel_y;
   assign pix.lum_in  = req_if.lum_in;

   // |dx|, |dy|, squares, near/far test against 160^2
   rsl_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (pix),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .out_valid (rad_vld),
      .out_ready (rad_rdy),
      .out_data  (rad_data)
   );

   // 8-bit root of the (near-only) squared distance
   rsl_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rad_vld),
      .in_ready  (rad_rdy),
      .in_data   (rad_data),
      .out_valid (sq_vld),
      .out_ready (sq_rdy),
      .out_data  (sq_data)
   );

   // lum * factor / 200, factor = 200 - d or 40 when far
   rsl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_vld),
      .in_ready  (sq_rdy),
      .in_data   (sq_data),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .lum_out   (rsp_if.lum_out)
   );

   // A ready response side never backs up to the request side
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_if.ready |-> req_if.ready)
      else $error("request side stalled while response side ready");

   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid right after reset");

   // A near pixel must have a root below the near limit
   a_near_root: assert property (@(posedge clock) disable iff (reset)
      (sq_vld && !sq_data.far) |-> (sq_data.root < NEAR_ROOT))
      else $error("near pixel with root at or above limit");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the radial spotlight luminance pipeline.
`timescale 1ns / 100ps

module tb;
   import rsl_pkg::*;

   // Falloff: scale (200 - d) / 200 inside the near radius, 1/5 outside it
   localparam int NEAR_DIST   = 160;
   localparam int FULL_SCALE  = 200;
   localparam int FAR_DIV     = 5;
   localparam int PIPE_LAT    = 10;    // request accept to response valid
   localparam int SETTLE_CYC  = PIPE_LAT + 6;
   localparam int HOLD_CYC    = 80;    // receiver hold-off, longer than the pipe
   localparam int WDOG_LIMIT  = 2000;
   localparam int IDLE_PCT    = 34;
   localparam int PHASE_ITEMS = 200;
   localparam int COORD_MAX   = (1 << COORD_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsl_req_if req_ch ();
   rsl_rsp_if rsp_ch ();
   rsl_csr_if csr_ch ();

   radial_spotlight_luminance_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to go out, and luminance values still owed by the block
   pix_type          pix_pending_q[$];
   logic [LUM_W-1:0] lum_expect_q[$];
   pix_type          pix_cur;

   // Center as the block should hold it, tracked from accepted register writes
   logic signed [CTR_W-1:0] center_x = '0;
   logic signed [CTR_W-1:0] center_y = '0;

   logic req_took    = 1'b0;  // request accepted at the last rising edge
   logic burst_mode  = 1'b0;  // no idling on either side
   logic hold_req    = 1'b0;  // ask the receiver for one long hold-off
   logic hold_taken  = 1'b0;
   int   hold_left   = 0;
   int   stall_cycles = 0;
   int   fail_cnt    = 0;

   // Expected output luminance for one pixel against a given center.
   // Distance is only needed up to the near radius, so the root search stops there.
   function automatic logic [LUM_W-1:0] spot_lum(input pix_type p,
                                                 input logic signed [CTR_W-1:0] cx,
                                                 input logic signed [CTR_W-1:0] cy);
      int                dx;
      int                dy;
      longint unsigned   dist_sq;
      longint unsigned   scaled;
      int                radius;
      dx = int'(p.pixel_x) - int'(cx);
      dy = int'(p.pixel_y) - int'(cy);
      if (dx < 0) begin
         dx = -dx;
      end
      if (dy < 0) begin
         dy = -dy;
      end
      dist_sq = longint'(dx) * dx + longint'(dy) * dy;
      radius = 0;
      while (radius < NEAR_DIST && longint'(radius + 1) * (radius + 1) <= dist_sq) begin
         radius++;
      end
      if (radius < NEAR_DIST) begin
         scaled = longint'(p.lum_in) * (FULL_SCALE - radius) / FULL_SCALE;
      end else begin
         scaled = longint'(p.lum_in) / FAR_DIV;
      end
      return scaled[LUM_W-1:0];
   endfunction

   // Request driver: presents the next pending pixel at the falling edge,
   // idling at random unless in burst mode.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         if (pix_pending_q.size() != 0 &&
             (burst_mode || $urandom_range(99) >= IDLE_PCT)) begin
            pix_cur = pix_pending_q.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.pixel_x <= pix_cur.pixel_x;
            req_ch.pixel_y <= pix_cur.pixel_y;
            req_ch.lum_in  <= pix_cur.lum_in;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus one long hold-off on request so the
   // pipeline fills and backs up into req_ch.ready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_taken   <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYC;
         hold_taken   <= 1'b1;
      end else begin
         rsp_ch.ready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor: predicts on request accept, checks on response accept, tracks
   // register writes and runs the watchdog.
   always @(posedge clock) begin : monitor
      logic [LUM_W-1:0] lum_exp;
      logic             req_fire;
      logic             rsp_fire;
      logic             csr_fire;
      req_fire = req_ch.valid && req_ch.ready;
      rsp_fire = rsp_ch.valid && rsp_ch.ready;
      csr_fire = csr_ch.valid && csr_ch.ready;
      if (reset) begin
         req_took     <= 1'b0;
         stall_cycles <= 0;
         center_x     <= '0;
         center_y     <= '0;
      end else begin
         req_took <= req_fire;
         if (rsp_fire) begin
            if (lum_expect_q.size() == 0) begin
               $error("unexpected response: lum_out %0d", rsp_ch.lum_out);
               fail_cnt++;
            end else begin
               lum_exp = lum_expect_q.pop_front();
               if (rsp_ch.lum_out !== lum_exp) begin
                  $error("lum_out mismatch: expected %0d, actual %0d",
                         lum_exp, rsp_ch.lum_out);
                  fail_cnt++;
               end
            end
         end
         if (req_fire) begin
            lum_expect_q.push_back(spot_lum('{req_ch.pixel_x, req_ch.pixel_y,
                                              req_ch.lum_in}, center_x, center_y));
         end
         if (csr_fire) begin
            case (csr_idx_type'(csr_ch.index))
               CSR_CENTER_X: begin
                  center_x <= csr_ch.data;
               end
               CSR_CENTER_Y: begin
                  center_y <= csr_ch.data;
               end
               default: begin
               end
            endcase
         end
         if (req_fire || rsp_fire || csr_fire) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // One register write; the block must be idle
   task automatic write_center(input csr_idx_type idx, input logic [CTR_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Waits until every request is out and answered, then lets the pipe settle.
   // The #1 lets the edge's nonblocking updates land before looking.
   task automatic drain;
      do begin
         @(posedge clock);
         #1;
      end while (pix_pending_q.size() != 0 || req_ch.valid || lum_expect_q.size() != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic queue_pixel(input int px, input int py, input int lum);
      pix_pending_q.push_back('{COORD_W'(px), COORD_W'(py), LUM_W'(lum)});
   endtask

   // Random pixels: mostly near the center so the falloff is exercised,
   // the rest anywhere or on the image border.
   task automatic queue_random(input int count, input logic signed [CTR_W-1:0] cx,
                               input logic signed [CTR_W-1:0] cy);
      int px;
      int py;
      int lum;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            px = int'(cx) + int'($urandom_range(440)) - 220;
            py = int'(cy) + int'($urandom_range(440)) - 220;
            px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
            py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
         end else if (pick < 85) begin
            px = $urandom_range(COORD_MAX);
            py = $urandom_range(COORD_MAX);
         end else begin
            px = $urandom_range(1) ? COORD_MAX : 0;
            py = $urandom_range(1) ? COORD_MAX : 0;
         end
         pick = $urandom_range(99);
         if (pick < 10) begin
            lum = (1 << LUM_W) - 1;
         end else if (pick < 20) begin
            lum = $urandom_range(255);
         end else begin
            lum = $urandom_range((1 << LUM_W) - 1);
         end
         queue_pixel(px, py, lum);
      end
   endtask

   initial begin
      logic signed [CTR_W-1:0] cx_list[6];
      logic signed [CTR_W-1:0] cy_list[6];
      logic signed [CTR_W-1:0] cx;
      logic signed [CTR_W-1:0] cy;

      req_ch.valid   = 1'b0;
      req_ch.pixel_x = '0;
      req_ch.pixel_y = '0;
      req_ch.lum_in  = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = CSR_CENTER_X;
      csr_ch.data    = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pass at the reset center (0, 0)
      queue_pixel(0, 0, 65535);
      queue_pixel(0, 0, 0);
      queue_pixel(0, 0, 1);
      queue_pixel(0, 0, 199);
      queue_pixel(0, 0, 200);
      queue_pixel(159, 0, 65535);     // last distance inside the falloff
      queue_pixel(160, 0, 65535);     // boundary: both formulas agree
      queue_pixel(161, 0, 65535);
      queue_pixel(96, 128, 65535);    // hypotenuse lands exactly on the boundary
      queue_pixel(95, 128, 65535);    // just inside, root rounds down to 159
      queue_pixel(113, 113, 65535);
      queue_pixel(0, 159, 54321);
      queue_pixel(4095, 4095, 65535);
      queue_pixel(4095, 0, 4);
      queue_pixel(0, 4095, 12345);
      queue_pixel(1, 1, 65535);
      drain();

      // Negative center off the image, then the far corners of the register range
      write_center(CSR_CENTER_X, -14'sd100);
      write_center(CSR_CENTER_Y, 14'sd50);
      queue_pixel(0, 50, 65535);      // d = 100 despite the negative center
      queue_pixel(59, 50, 65535);     // d = 159
      queue_pixel(60, 50, 65535);     // d = 160
      queue_pixel(0, 0, 30000);
      queue_random(PHASE_ITEMS, -14'sd100, 14'sd50);
      drain();

      cx_list = '{-14'sd8192, 14'sd8191, 14'sd2048, 14'sd4150, -14'sd4096, 14'sd8191};
      cy_list = '{-14'sd8192, 14'sd8191, 14'sd2048, 14'sd10, 14'sd8191, -14'sd4096};
      for (int ph = 0; ph < 6; ph++) begin
         write_center(CSR_CENTER_X, cx_list[ph]);
         write_center(CSR_CENTER_Y, cy_list[ph]);
         if (ph == 2) begin
            // Full-rate sender against one long receiver hold-off: the
            // pipeline fills and the input must stall without losing items.
            @(negedge clock);
            burst_mode <= 1'b1;
            hold_req   <= 1'b1;
         end
         queue_random(PHASE_ITEMS, cx_list[ph], cy_list[ph]);
         drain();
         if (ph == 2) begin
            @(negedge clock);
            burst_mode <= 1'b0;
         end
      end

      // Random centers: half near the image, half anywhere in the register range
      for (int ph = 0; ph < 3; ph++) begin
         if ($urandom_range(1)) begin
            cx = CTR_W'(int'($urandom_range(4500)) - 200);
            cy = CTR_W'(int'($urandom_range(4500)) - 200);
         end else begin
            cx = CTR_W'($urandom_range((1 << CTR_W) - 1));
            cy = CTR_W'($urandom_range((1 << CTR_W) - 1));
         end
         write_center(CSR_CENTER_X, cx);
         write_center(CSR_CENTER_Y, cy);
         queue_random(PHASE_ITEMS, cx, cy);
         drain();
      end

      if (fail_cnt == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
